// File: sv/gld_pkg.sv
package gld_pkg;

    localparam int STATUS_W = 3;
    localparam int PIXEL_W  = 8;
    localparam int ROOT_W   = 4;
    localparam int BUF_W    = 24;
    localparam int HELD_W   = 5;

    localparam logic [ROOT_W-1:0] ROOT_BITS_RESET = 4'd8;
    localparam logic [ROOT_W-1:0] ROOT_BITS_MIN   = 4'd2;
    localparam logic [ROOT_W-1:0] ROOT_BITS_MAX   = 4'd8;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_PIXEL     = 3'd0;
    localparam logic [STATUS_W-1:0] ST_TAKEN     = 3'd1;
    localparam logic [STATUS_W-1:0] ST_NEED      = 3'd2;
    localparam logic [STATUS_W-1:0] ST_CLEARED   = 3'd3;
    localparam logic [STATUS_W-1:0] ST_ENDED     = 3'd4;
    localparam logic [STATUS_W-1:0] ST_REJECTED  = 3'd5;
    localparam logic [STATUS_W-1:0] ST_NOT_CLEAR = 3'd6;

    typedef enum logic [1:0] {
        PH_EXPECT_CLEAR = 2'd0,
        PH_FIRST_CODE   = 2'd1,
        PH_DECODING     = 2'd2,
        PH_ENDED        = 2'd3
    } phase_t;

    typedef enum logic [4:0] {
        S_IDLE    = 5'b00001,
        S_FIRST   = 5'b00010,
        S_WALK    = 5'b00100,
        S_POP     = 5'b01000,
        S_EMIT    = 5'b10000
    } state_t;

    function automatic logic [ROOT_W-1:0] clamp_root(input logic [ROOT_W-1:0] v);
        logic [ROOT_W-1:0] r;
        r = v;
        if (v < ROOT_BITS_MIN) begin
            r = ROOT_BITS_MIN;
        end else if (v > ROOT_BITS_MAX) begin
            r = ROOT_BITS_MAX;
        end
        return r;
    endfunction

endpackage

// File: sv/gld_ram.sv
module gld_ram #(
    parameter int AW    = 12,
    parameter int WIDTH = 8
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [(1 << AW)];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        rdata <= mem[raddr];
    end

endmodule

// File: sv/gld_core.sv
module gld_core #(
    parameter int MAX_CODE_BITS = 12
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_wr_en,
    input  logic [gld_pkg::ROOT_W-1:0]    cfg_wr_data,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic                          in_kind,
    input  logic [7:0]                    in_byte,
    output logic                          res_valid,
    input  logic                          res_ready,
    output logic [gld_pkg::STATUS_W-1:0]  res_status,
    output logic [gld_pkg::PIXEL_W-1:0]   res_pixel,
    output logic                          dict_we,
    output logic [MAX_CODE_BITS-1:0]      dict_waddr,
    output logic [MAX_CODE_BITS+15:0]     dict_wdata,
    output logic [MAX_CODE_BITS-1:0]      dict_raddr,
    input  logic [MAX_CODE_BITS+15:0]     dict_rdata,
    output logic                          stk_we,
    output logic [MAX_CODE_BITS-1:0]      stk_waddr,
    output logic [7:0]                    stk_wdata,
    output logic [MAX_CODE_BITS-1:0]      stk_raddr,
    input  logic [7:0]                    stk_rdata
);

    localparam int CB = MAX_CODE_BITS;
    localparam int NB = MAX_CODE_BITS + 1;
    localparam logic [NB-1:0] TE = NB'(1) << CB;
    localparam logic [3:0] CW_MAX = 4'(MAX_CODE_BITS);

    gld_pkg::state_t state_reg, state_next;
    gld_pkg::phase_t phase_reg, phase_next;
    logic [gld_pkg::ROOT_W-1:0]   cfg_reg;
    logic [gld_pkg::BUF_W-1:0]    buf_reg, buf_next;
    logic [gld_pkg::HELD_W-1:0]   held_reg, held_next;
    logic [3:0]                   cw_reg, cw_next;
    logic [NB-1:0]                next_reg, next_next;
    logic [CB-1:0]                prev_reg, prev_next;
    logic [7:0]                   pfirst_reg, pfirst_next;
    logic [NB-1:0]                depth_reg, depth_next;
    logic [CB-1:0]                c_reg, c_next;
    logic [gld_pkg::STATUS_W-1:0] rs_reg, rs_next;
    logic [gld_pkg::PIXEL_W-1:0]  px_reg, px_next;

    logic [gld_pkg::ROOT_W-1:0] rb, rbw;
    logic [CB-1:0]              clr_code, end_code, code, root_code;
    logic [NB-1:0]              ne1;
    logic [3:0]                 cw_grown;
    logic [NB-1:0]              depth_m1;
    logic [CB-1:0]              rd_prefix, walk_c;
    logic [7:0]                 rd_suffix, rd_first, f_code;

    assign rb        = gld_pkg::clamp_root(cfg_reg);
    assign rbw       = gld_pkg::clamp_root(cfg_wr_data);
    assign clr_code  = CB'(1) << rb;
    assign end_code  = clr_code + CB'(1);
    assign code      = CB'(buf_reg & ((gld_pkg::BUF_W'(1) << cw_reg) - gld_pkg::BUF_W'(1)));
    assign root_code = code & (clr_code - CB'(1));
    assign ne1       = next_reg + NB'(1);
    assign cw_grown  = (ne1 >= (NB'(1) << cw_reg) && cw_reg < CW_MAX) ? cw_reg + 4'd1 : cw_reg;
    assign depth_m1  = depth_reg - NB'(1);

    // dictionary word: prefix | suffix | first
    assign rd_prefix = dict_rdata[CB+15:16];
    assign rd_suffix = dict_rdata[15:8];
    assign rd_first  = dict_rdata[7:0];
    assign f_code    = (c_reg > end_code) ? rd_first : c_reg[7:0];
    assign walk_c    = rd_prefix;

    assign in_ready   = (state_reg == gld_pkg::S_IDLE);
    assign res_valid  = (state_reg == gld_pkg::S_EMIT);
    assign res_status = rs_reg;
    assign res_pixel  = px_reg;
    assign dict_raddr = c_next;
    assign stk_raddr  = depth_m1[CB-1:0];

    always_comb begin
        state_next  = state_reg;
        phase_next  = phase_reg;
        buf_next    = buf_reg;
        held_next   = held_reg;
        cw_next     = cw_reg;
        next_next   = next_reg;
        prev_next   = prev_reg;
        pfirst_next = pfirst_reg;
        depth_next  = depth_reg;
        c_next      = c_reg;
        rs_next     = rs_reg;
        px_next     = px_reg;
        dict_we     = 1'b0;
        dict_waddr  = next_reg[CB-1:0];
        dict_wdata  = {prev_reg, pfirst_reg, pfirst_reg};
        stk_we      = 1'b0;
        stk_waddr   = depth_reg[CB-1:0];
        stk_wdata   = pfirst_reg;

        case (state_reg)
            gld_pkg::S_IDLE: begin
                if (in_valid) begin
                    px_next    = '0;
                    state_next = gld_pkg::S_EMIT;
                    if (!in_kind) begin
                        if (phase_reg == gld_pkg::PH_ENDED || held_reg > 5'd16) begin
                            rs_next = gld_pkg::ST_REJECTED;
                        end else begin
                            buf_next  = buf_reg |
                                (gld_pkg::BUF_W'(in_byte) << held_reg);
                            held_next = held_reg + 5'd8;
                            rs_next   = gld_pkg::ST_TAKEN;
                        end
                    end else if (depth_reg != '0) begin
                        depth_next = depth_m1;
                        state_next = gld_pkg::S_POP;
                    end else if (phase_reg == gld_pkg::PH_ENDED) begin
                        rs_next = gld_pkg::ST_ENDED;
                    end else if (held_reg < {1'b0, cw_reg}) begin
                        rs_next = gld_pkg::ST_NEED;
                    end else begin
                        buf_next  = buf_reg >> cw_reg;
                        held_next = held_reg - {1'b0, cw_reg};
                        if (code == clr_code) begin
                            cw_next    = rb + 4'd1;
                            next_next  = NB'(clr_code) + NB'(2);
                            phase_next = gld_pkg::PH_FIRST_CODE;
                            rs_next    = gld_pkg::ST_CLEARED;
                        end else if (phase_reg == gld_pkg::PH_EXPECT_CLEAR) begin
                            rs_next = gld_pkg::ST_NOT_CLEAR;
                        end else if (code == end_code) begin
                            phase_next = gld_pkg::PH_ENDED;
                            rs_next    = gld_pkg::ST_ENDED;
                        end else if (phase_reg == gld_pkg::PH_FIRST_CODE) begin
                            prev_next   = root_code;
                            pfirst_next = root_code[7:0];
                            phase_next  = gld_pkg::PH_DECODING;
                            rs_next     = gld_pkg::ST_PIXEL;
                            px_next     = root_code[7:0];
                        end else if ({1'b0, code} < next_reg) begin
                            // known code: need its first byte from the table
                            c_next     = code;
                            state_next = gld_pkg::S_FIRST;
                        end else begin
                            // KwKwK: new entry is prev + first(prev), known now
                            dict_we    = 1'b1;
                            stk_we     = 1'b1;
                            depth_next = depth_reg + NB'(1);
                            next_next  = ne1;
                            cw_next    = cw_grown;
                            prev_next  = next_reg[CB-1:0];
                            c_next     = prev_reg;
                            if (prev_reg > end_code) begin
                                state_next = gld_pkg::S_WALK;
                            end else begin
                                rs_next = gld_pkg::ST_PIXEL;
                                px_next = prev_reg[7:0];
                            end
                        end
                    end
                end
            end
            gld_pkg::S_FIRST: begin
                if (next_reg < TE) begin
                    dict_we    = 1'b1;
                    dict_wdata = {prev_reg, f_code, pfirst_reg};
                    next_next  = ne1;
                    cw_next    = cw_grown;
                end
                prev_next   = c_reg;
                pfirst_next = f_code;
                if (c_reg > end_code) begin
                    state_next = gld_pkg::S_WALK;
                end else begin
                    rs_next    = gld_pkg::ST_PIXEL;
                    px_next    = c_reg[7:0];
                    state_next = gld_pkg::S_EMIT;
                end
            end
            gld_pkg::S_WALK: begin
                stk_we     = 1'b1;
                stk_wdata  = rd_suffix;
                depth_next = depth_reg + NB'(1);
                c_next     = walk_c;
                if (walk_c <= end_code) begin
                    rs_next    = gld_pkg::ST_PIXEL;
                    px_next    = walk_c[7:0];
                    state_next = gld_pkg::S_EMIT;
                end
            end
            gld_pkg::S_POP: begin
                rs_next    = gld_pkg::ST_PIXEL;
                px_next    = stk_rdata;
                state_next = gld_pkg::S_EMIT;
            end
            gld_pkg::S_EMIT: begin
                if (res_ready) begin
                    state_next = gld_pkg::S_IDLE;
                end
            end
            default: begin
                state_next = gld_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg    <= gld_pkg::ROOT_BITS_RESET;
            state_reg  <= gld_pkg::S_IDLE;
            phase_reg  <= gld_pkg::PH_EXPECT_CLEAR;
            buf_reg    <= '0;
            held_reg   <= '0;
            cw_reg     <= gld_pkg::ROOT_BITS_RESET + 4'd1;
            next_reg   <= (NB'(1) << gld_pkg::ROOT_BITS_RESET) + NB'(2);
            prev_reg   <= '0;
            pfirst_reg <= '0;
            depth_reg  <= '0;
        end else if (cfg_wr_en) begin
            cfg_reg    <= cfg_wr_data;
            state_reg  <= gld_pkg::S_IDLE;
            phase_reg  <= gld_pkg::PH_EXPECT_CLEAR;
            buf_reg    <= '0;
            held_reg   <= '0;
            cw_reg     <= rbw + 4'd1;
            next_reg   <= (NB'(1) << rbw) + NB'(2);
            prev_reg   <= '0;
            pfirst_reg <= '0;
            depth_reg  <= '0;
        end else begin
            state_reg  <= state_next;
            phase_reg  <= phase_next;
            buf_reg    <= buf_next;
            held_reg   <= held_next;
            cw_reg     <= cw_next;
            next_reg   <= next_next;
            prev_reg   <= prev_next;
            pfirst_reg <= pfirst_next;
            depth_reg  <= depth_next;
        end
    end

    always_ff @(posedge aclk) begin
        c_reg  <= c_next;
        rs_reg <= rs_next;
        px_reg <= px_next;
    end

    a_held_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        held_reg <= 5'd24)
        else $error("bit buffer overfilled");

    a_depth_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        depth_reg <= TE)
        else $error("string stack overflow");

    a_walk_nonroot: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == gld_pkg::S_WALK |-> c_reg > end_code)
        else $error("chain walk on a root code");

    a_dict_room: assert property (@(posedge aclk) disable iff (!aresetn)
        dict_we |-> next_reg < TE)
        else $error("dictionary write past table end");

    a_cw_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cw_reg > rb && cw_reg <= CW_MAX)
        else $error("code width out of range");

endmodule

// File: sv/gif_lzw_decoder.sv
// Channel   Dir  tdata               tuser        tlast
// s_        in   [7:0] data_byte     [0] req_type  -
// m_        out  [7:0] pixel         [2:0] status  -
// cfg_wr_*  in   root_code_bits (4b), write-only, no handshake
//
// Path: a byte push goes through the core's result register into the output register,
// and a pull served from the string stack adds a stack RAM read before them; a pull that
// decodes a new code walks the string's prefix chain through the single dictionary read
// port, one prefix link per cycle.
// Reset (aresetn low, synchronous) or a cfg write restarts the decoder; the
// RAMs are not cleared, root entries are computed, not stored.
// A stalled m_ transfer holds the result; s_tready drops until it drains.
module gif_lzw_decoder #(
    parameter int MAX_CODE_BITS = 12
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [3:0]  cfg_wr_data,   // root_code_bits
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,       // [7:0] data_byte
    input  logic [0:0]  s_tuser,       // [0] req_type
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,       // [7:0] pixel
    output logic [2:0]  m_tuser        // [2:0] status
);

    localparam int CB = MAX_CODE_BITS;
    localparam int DW = MAX_CODE_BITS + 16;

    logic                          res_valid, res_ready;
    logic [gld_pkg::STATUS_W-1:0]  res_status;
    logic [gld_pkg::PIXEL_W-1:0]   res_pixel;
    logic                          dict_we, stk_we;
    logic [CB-1:0]                 dict_waddr, dict_raddr, stk_waddr, stk_raddr;
    logic [DW-1:0]                 dict_wdata, dict_rdata;
    logic [7:0]                    stk_wdata, stk_rdata;

    logic                          m_tvalid_reg;
    logic [gld_pkg::STATUS_W-1:0]  status_reg;
    logic [gld_pkg::PIXEL_W-1:0]   pixel_reg;

    gld_core #(.MAX_CODE_BITS(MAX_CODE_BITS)) u_core (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_kind    (s_tuser[0]),
        .in_byte    (s_tdata),
        .res_valid  (res_valid),
        .res_ready  (res_ready),
        .res_status (res_status),
        .res_pixel  (res_pixel),
        .dict_we    (dict_we),
        .dict_waddr (dict_waddr),
        .dict_wdata (dict_wdata),
        .dict_raddr (dict_raddr),
        .dict_rdata (dict_rdata),
        .stk_we     (stk_we),
        .stk_waddr  (stk_waddr),
        .stk_wdata  (stk_wdata),
        .stk_raddr  (stk_raddr),
        .stk_rdata  (stk_rdata)
    );

    // dictionary: prefix, suffix, first byte per entry
    gld_ram #(.AW(CB), .WIDTH(DW)) u_dict (
        .aclk (aclk),
        .we   (dict_we),
        .waddr(dict_waddr),
        .wdata(dict_wdata),
        .raddr(dict_raddr),
        .rdata(dict_rdata)
    );

    // string stack, popped one pixel per pull
    gld_ram #(.AW(CB), .WIDTH(8)) u_stack (
        .aclk (aclk),
        .we   (stk_we),
        .waddr(stk_waddr),
        .wdata(stk_wdata),
        .raddr(stk_raddr),
        .rdata(stk_rdata)
    );

    // output register: loads when empty or draining this cycle
    assign res_ready = !m_tvalid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (res_ready) begin
            m_tvalid_reg <= res_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_ready && res_valid) begin
            status_reg <= res_status;
            pixel_reg  <= res_pixel;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = pixel_reg;
    assign m_tuser  = status_reg;

endmodule
